@@ rtl/core/ptfd_pkg.sv @@
// Shared types and constants of the path time stamping block.
package ptfd_pkg;

  // Field widths
  localparam int CoordW = 24;
  localparam int StampW = 63;
  localparam int DistW  = 48;
  localparam int SpeedW = 24;
  localparam int PaddrW = 3;
  localparam int DataW  = 32;

  // Datapath widths
  localparam int MulAW  = 24;
  localparam int MulBW  = 30;
  localparam int ProdW  = MulAW + MulBW;
  localparam int RadW   = 66;
  localparam int RootW  = 33;
  localparam int RemW   = RootW + 2;
  localparam int NumW   = DistW + MulBW;
  localparam int CntW   = 7;

  localparam int SqrtSteps = RootW;
  localparam int DivSteps  = NumW;

  localparam logic [MulBW-1:0]  NsPerS     = 30'd1000000000;
  localparam logic [SpeedW-1:0] SpeedReset = 24'd256;
  localparam logic [SpeedW-1:0] SpeedMin   = 24'd1;

  // Register index, taken from paddr[2]
  localparam logic RegSpeed = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic                     first_point;
    logic [StampW-1:0]        start_stamp;
  } in_word_t;

  typedef struct packed {
    logic [StampW-1:0] point_stamp;
    logic [DistW-1:0]  path_length;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SQRT,
    S_ACC,
    S_MLO,
    S_MHI,
    S_MSUM,
    S_DIV,
    S_STAMP,
    S_DONE
  } state_e;

  // Status from the core to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

@@ rtl/core/path_time_from_distance.sv @@
// Path time stamping from travelled distance: top level with register and handshakes.
//
// A first point goes straight to the done state with its own start stamp and a path
// length of zero. Every later point takes these steps: square and add the coordinate
// differences on the shared 24x30 multiplier, the restoring square root (one root bit
// per cycle), an add into the saturating distance, distance times 10^9 on the same
// multiplier, the restoring divider by speed (one quotient bit per cycle) and the
// saturating stamp add. The input stalls while a point is being worked on; the finished
// word waits in an output register, and a new point is taken as soon as the core has
// handed its word over. The speed register sits at byte address 0; writing 0 stores 1.
module path_time_from_distance (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ptfd_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ptfd_pkg::out_word_t  out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ptfd_pkg::*;

  logic [SpeedW-1:0] speed_q;
  logic              out_valid_q;
  out_word_t         out_q;
  core_stat_t        stat;
  out_word_t         res;
  logic              in_acc, take, cfg_wr;

  // Handshakes
  assign in_stall_o = stat.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign take       = stat.done && (!out_valid_q || !out_stall_i);

  ptfd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .in_word_i (in_word_i),
    .speed_i   (speed_q),
    .take_i    (take),
    .stat_o    (stat),
    .res_o     (res)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegSpeed) ? {{(DataW-SpeedW){1'b0}}, speed_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedReset;
    end else if (cfg_wr && paddr[2] == RegSpeed) begin
      speed_q <= (pwdata[SpeedW-1:0] == '0) ? SpeedMin : pwdata[SpeedW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/core/ptfd_core.sv @@
// Sequencer and shared datapath: segment length, running distance, time stamp.
module ptfd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ptfd_pkg::in_word_t   in_word_i,
  input  logic [23:0]          speed_i,
  input  logic                 take_i,
  output ptfd_pkg::core_stat_t stat_o,
  output ptfd_pkg::out_word_t  res_o
);
  import ptfd_pkg::*;

  state_e state_q, state_d;

  // Trajectory state
  logic [CoordW-1:0] prev_x_q, prev_y_q;
  logic [DistW-1:0]  dist_q;
  logic [StampW-1:0] base_q;
  logic [CntW-1:0]   cnt_q;

  // Working registers
  logic [CoordW-1:0] dx_q, dy_q;
  logic [ProdW-1:0]  p_q, s_q;
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [NumW-1:0]   num_q;
  logic [SpeedW-1:0] drem_q;
  out_word_t         res_q;

  // Absolute differences against the previous point
  logic [CoordW:0]   dx_s, dy_s, dx_n, dy_n;
  always_comb begin
    dx_s = {in_word_i.pos_x[CoordW-1], in_word_i.pos_x} - {prev_x_q[CoordW-1], prev_x_q};
    dy_s = {in_word_i.pos_y[CoordW-1], in_word_i.pos_y} - {prev_y_q[CoordW-1], prev_y_q};
    dx_n = dx_s[CoordW] ? (~dx_s + 1'b1) : dx_s;
    dy_n = dy_s[CoordW] ? (~dy_s + 1'b1) : dy_s;
  end

  // Shared multiplier: two squares, then two halves of distance times 10^9
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;
  always_comb begin
    case (state_q)
      S_SQX: begin
        mul_a = dx_q;
        mul_b = {{(MulBW-MulAW){1'b0}}, dx_q};
      end
      S_SQY: begin
        mul_a = dy_q;
        mul_b = {{(MulBW-MulAW){1'b0}}, dy_q};
      end
      S_MLO: begin
        mul_a = dist_q[MulAW-1:0];
        mul_b = NsPerS;
      end
      S_MHI: begin
        mul_a = dist_q[DistW-1:MulAW];
        mul_b = NsPerS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
  end

  // One root bit per step
  logic [RemW+1:0] sq_rem_n, sq_trial, sq_diff;
  logic            sq_ge;
  always_comb begin
    sq_rem_n = {rem_q, rad_q[RadW-1:RadW-2]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = sq_rem_n >= sq_trial;
    sq_diff  = sq_rem_n - sq_trial;
  end

  // One quotient bit per step
  logic [SpeedW:0] dv_rem_n, dv_diff;
  logic            dv_ge;
  always_comb begin
    dv_rem_n = {drem_q, num_q[NumW-1]};
    dv_ge    = dv_rem_n >= {1'b0, speed_i};
    dv_diff  = dv_rem_n - {1'b0, speed_i};
  end

  // Sums: squares, running distance, final stamp
  logic [ProdW-1:0]  sp_sum;
  logic [DistW:0]    acc_sum;
  logic [DistW-1:0]  acc_sat;
  logic [63:0]       t_ns;
  logic [StampW+1:0] st_sum;
  logic [StampW-1:0] st_sat;
  always_comb begin
    sp_sum  = s_q + p_q;
    acc_sum = {1'b0, dist_q} + {{(DistW+1-RootW){1'b0}}, root_q};
    acc_sat = acc_sum[DistW] ? {DistW{1'b1}} : acc_sum[DistW-1:0];
    t_ns    = (|num_q[NumW-1:64]) ? {64{1'b1}} : num_q[63:0];
    st_sum  = {2'b00, base_q} + {1'b0, t_ns};
    st_sat  = (|st_sum[StampW+1:StampW]) ? {StampW{1'b1}} : st_sum[StampW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = in_word_i.first_point ? S_DONE : S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SUM;
      S_SUM:   state_d = S_SQRT;
      S_SQRT:  if (cnt_q == '0) state_d = S_ACC;
      S_ACC:   state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_MSUM;
      S_MSUM:  state_d = S_DIV;
      S_DIV:   if (cnt_q == '0) state_d = S_STAMP;
      S_STAMP: state_d = S_DONE;
      S_DONE:  if (take_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat_o.busy = (state_q != S_IDLE);
    stat_o.done = (state_q == S_DONE);
    res_o       = res_q;
  end

  // Sequencer and trajectory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      dist_q   <= '0;
      base_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            prev_x_q <= in_word_i.pos_x;
            prev_y_q <= in_word_i.pos_y;
            if (in_word_i.first_point) begin
              dist_q <= '0;
              base_q <= in_word_i.start_stamp;
            end
          end
        end
        S_SUM:   cnt_q  <= CntW'(SqrtSteps - 1);
        S_SQRT:  cnt_q  <= cnt_q - 1'b1;
        S_ACC:   dist_q <= acc_sat;
        S_MSUM:  cnt_q  <= CntW'(DivSteps - 1);
        S_DIV:   cnt_q  <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dx_q <= dx_n[CoordW-1:0];
        dy_q <= dy_n[CoordW-1:0];
        if (start_i && in_word_i.first_point) begin
          res_q.point_stamp <= in_word_i.start_stamp;
          res_q.path_length <= '0;
        end
      end
      S_SQX: p_q <= mul_p;
      S_SQY: begin
        s_q <= p_q;
        p_q <= mul_p;
      end
      S_SUM: begin
        rad_q  <= {sp_sum[RadW-17:0], 16'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        rem_q  <= sq_ge ? sq_diff[RemW-1:0] : sq_rem_n[RemW-1:0];
        root_q <= {root_q[RootW-2:0], sq_ge};
      end
      S_MLO: p_q <= mul_p;
      S_MHI: begin
        s_q <= p_q;
        p_q <= mul_p;
      end
      S_MSUM: begin
        num_q  <= {{(NumW-ProdW){1'b0}}, s_q} + {p_q, {(NumW-ProdW){1'b0}}};
        drem_q <= '0;
      end
      S_DIV: begin
        drem_q <= dv_ge ? dv_diff[SpeedW-1:0] : dv_rem_n[SpeedW-1:0];
        num_q  <= {num_q[NumW-2:0], dv_ge};
      end
      S_STAMP: begin
        res_q.point_stamp <= st_sat;
        res_q.path_length <= dist_q;
      end
      default: ;
    endcase
  end

  // Checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("word accepted while busy");

  a_take_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> state_q == S_DONE) else $error("result taken before it is ready");

  a_first_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && in_word_i.first_point) |=> state_q == S_DONE)
    else $error("first point did not answer at once");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> rem_q <= {1'b0, root_q, 1'b0})
    else $error("root remainder out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && speed_i != '0) |-> drem_q < speed_i)
    else $error("divider remainder out of range");

endmodule
